FILE: rtl/sacg_pkg.sv
// Shared types, constants and the gamma table of the segmented average colour unit.
package sacg_pkg;

  localparam int CNT_W = 13;
  localparam int PIX_W = 8;
  localparam int Q_W = 8;
  localparam int LUM_W = 22;
  localparam int GAMMA_DEPTH = 511;
  localparam int GAMMA_IDX_W = 9;
  localparam int LUT_MATH_W = 128;

  localparam logic [LUM_W-1:0] LumWeightR = LUM_W'(2126);
  localparam logic [LUM_W-1:0] LumWeightG = LUM_W'(7152);
  localparam logic [LUM_W-1:0] LumWeightB = LUM_W'(722);

  typedef logic [1:0] chan_t;
  localparam chan_t ChRed = 2'd0;
  localparam chan_t ChGreen = 2'd1;
  localparam chan_t ChBlue = 2'd2;

  typedef struct packed {
    logic  accum;
    logic  div_start;
    logic  div_global;
    logic  store_seg;
    logic  lum_step;
    logic  store_glob;
    logic  load_out;
    logic  clear;
    chan_t chan;
  } sacg_cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic seg_empty;
    logic div_done;
    logic out_free;
  } sacg_status_t;

  typedef logic [Q_W-1:0] gamma_lut_t [GAMMA_DEPTH];

  // Largest v with v^5 * 2^11 * 255^6 <= s^11, found by binary search per entry.
  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t lut;
    logic [LUT_MATH_W-1:0] scale;
    logic [LUT_MATH_W-1:0] rhs;
    logic [LUT_MATH_W-1:0] lhs;
    int lo;
    int hi;
    int mid;
    int s;
    int i;
    scale = LUT_MATH_W'(2048);
    for (i = 0; i < 6; i++) scale = scale * LUT_MATH_W'(255);
    for (s = 0; s < GAMMA_DEPTH; s++) begin
      rhs = LUT_MATH_W'(s);
      for (i = 0; i < 10; i++) rhs = rhs * LUT_MATH_W'(s);
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = LUT_MATH_W'(mid);
        for (i = 0; i < 4; i++) lhs = lhs * LUT_MATH_W'(mid);
        lhs = lhs * scale;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      lut[s] = Q_W'(lo);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GammaLut = build_gamma_lut();

endpackage

FILE: rtl/segmented_average_color_gamma_unit.sv
// Segmented average colour unit with brightest-segment blend and gamma 2.2 output.
//
// Pixels stream in one per cycle while a frame accumulates: the unit keeps channel sums for
// the whole frame and for SEGMENT_COUNT segments of pixel_count / SEGMENT_COUNT pixels each,
// the last segment taking the remainder. On the last pixel of a frame the input stalls while
// the frame is reduced. Every segment average and the global average come from one shared
// divider, which builds the quotient bit by bit and finishes at once when it saturates at 255.
// The stall covers three divisions and one compare step per non-empty segment, a skip over
// each empty segment, three divisions for the global average and the hand-over of the result.
// The brightest segment by integer luminance 2126 R + 7152 G + 722 B (first one on ties,
// segment 0 when all are dark) is added to the global average and each channel goes through a
// 511-entry gamma table. One colour transaction leaves per frame through an output register, so
// the next frame starts while the result still waits; a second result stalls only if the first
// is still untaken. Empty segments (pixel_count below SEGMENT_COUNT) are skipped. Write
// pixel_count only between pixel transactions; a value of 0 acts as 1 and values above
// MAX_PIXELS are clamped.
module segmented_average_color_gamma_unit import sacg_pkg::*; #(
  parameter int MAX_PIXELS = 4096,
  parameter int SEGMENT_COUNT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel_count register write
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  // pixel transactions
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  // colour transactions
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata   // red_out [7:0], green_out [15:8],
                                          // blue_out [23:16], brightest_segment [25:24]
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);

  sacg_cmd_t        cmd;
  sacg_status_t     status;
  logic [SEG_W-1:0] seg;
  logic [3*Q_W+1:0] out_data;

  sacg_ctrl #(
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd),
    .seg_o     (seg)
  );

  sacg_dp #(
    .MAX_PIXELS   (MAX_PIXELS),
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (s_axis_tdata),
    .cmd_i      (cmd),
    .seg_i      (seg),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  // Pad the colour transaction to whole bytes.
  assign m_axis_tdata = {6'd0, out_data};

endmodule

FILE: rtl/sacg_div.sv
// Iterative 8-bit quotient divider with saturation to 255.
module sacg_div import sacg_pkg::*; #(
  parameter int DIVIDEND_W = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [Q_W-1:0]        quot_o
);

  localparam int WIDE_A = DIVIDEND_W;
  localparam int WIDE_B = CNT_W + Q_W;
  localparam int RW = ((WIDE_A > WIDE_B) ? WIDE_A : WIDE_B) + 1;
  localparam int STEP_W = $clog2(Q_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [RW-1:0]     rem_q;
  logic [RW-1:0]     dsh_q;
  logic [Q_W-1:0]    quot_q;

  logic [RW-1:0] dividend_ext;
  logic [RW-1:0] full_scale;
  logic          saturate;
  logic          fits;

  assign dividend_ext = RW'(dividend_i);
  assign full_scale = RW'(divisor_i) << Q_W;
  assign saturate = dividend_ext >= full_scale;
  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !saturate;
        done_q <= saturate;
        step_q <= STEP_W'(Q_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_ext;
      dsh_q <= RW'(divisor_i) << (Q_W - 1);
      quot_q <= saturate ? '1 : '0;
    end else if (busy_q) begin
      if (fits) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quot_q <= {quot_q[Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/sacg_ctrl.sv
// Frame sequencer: accumulation, per-segment and global averaging, compare, gamma and output.
module sacg_ctrl import sacg_pkg::*; #(
  parameter int SEGMENT_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sacg_status_t                     status_i,
  output sacg_cmd_t                        cmd_o,
  output logic [$clog2(SEGMENT_COUNT)-1:0] seg_o
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);
  localparam logic [SEG_W-1:0] SegLast = SEG_W'(SEGMENT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SEG_START,
    ST_SEG_WAIT,
    ST_LUM,
    ST_GLB_START,
    ST_GLB_WAIT,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [SEG_W-1:0] seg_q;
  chan_t            chan_q;
  logic             accept;

  assign in_ready_o = (state_q == ST_ACCUM);
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      seg_q <= '0;
      chan_q <= ChRed;
    end else begin
      case (state_q)
        ST_ACCUM: begin
          if (accept && status_i.last_pixel) begin
            state_q <= ST_SEG_START;
            seg_q <= '0;
            chan_q <= ChRed;
          end
        end
        ST_SEG_START: begin
          if (!status_i.seg_empty) begin
            state_q <= ST_SEG_WAIT;
          end else if (seg_q == SegLast) begin
            state_q <= ST_GLB_START;
            chan_q <= ChRed;
          end else begin
            seg_q <= seg_q + 1'b1;
          end
        end
        ST_SEG_WAIT: begin
          if (status_i.div_done) begin
            if (chan_q == ChBlue) begin
              state_q <= ST_LUM;
              chan_q <= ChRed;
            end else begin
              state_q <= ST_SEG_START;
              chan_q <= chan_q + 1'b1;
            end
          end
        end
        ST_LUM: begin
          if (seg_q == SegLast) begin
            state_q <= ST_GLB_START;
          end else begin
            state_q <= ST_SEG_START;
            seg_q <= seg_q + 1'b1;
          end
        end
        ST_GLB_START: begin
          state_q <= ST_GLB_WAIT;
        end
        ST_GLB_WAIT: begin
          if (status_i.div_done) begin
            if (chan_q == ChBlue) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_GLB_START;
              chan_q <= chan_q + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (status_i.out_free) state_q <= ST_ACCUM;
        end
        default: begin
          state_q <= ST_ACCUM;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.chan = chan_q;
    cmd_o.accum = accept;
    case (state_q)
      ST_SEG_START: cmd_o.div_start = !status_i.seg_empty;
      ST_SEG_WAIT:  cmd_o.store_seg = status_i.div_done;
      ST_LUM:       cmd_o.lum_step = 1'b1;
      ST_GLB_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_global = 1'b1;
      end
      ST_GLB_WAIT:  cmd_o.store_glob = status_i.div_done;
      ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.clear = status_i.out_free;
      end
      default: ;
    endcase
  end

  assign seg_o = seg_q;

endmodule

FILE: rtl/sacg_dp.sv
// Datapath: count register, channel sums, averaging, brightness compare, gamma lookup and output register.
module sacg_dp import sacg_pkg::*; #(
  parameter int MAX_PIXELS = 4096,
  parameter int SEGMENT_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CNT_W-1:0]                 cfg_data_i,
  input  logic [3*PIX_W-1:0]               pixel_i,
  input  sacg_cmd_t                        cmd_i,
  input  logic [$clog2(SEGMENT_COUNT)-1:0] seg_i,
  output sacg_status_t                     status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3*Q_W+1:0]                 out_data_o
);

  localparam int SEG_W = $clog2(SEGMENT_COUNT);
  localparam int IDX_W = $clog2(MAX_PIXELS);
  localparam int SUM_W = $clog2(MAX_PIXELS * 255 + 1);
  localparam int BND_W = CNT_W + $clog2(SEGMENT_COUNT + 1);
  localparam int CMP_W = ((BND_W > IDX_W) ? BND_W : IDX_W) + 1;
  localparam int RECIP_SHIFT = CNT_W + $clog2(SEGMENT_COUNT) + 1;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W = CNT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] Recip = RECIP_W'((64'd1 << RECIP_SHIFT) / SEGMENT_COUNT + 1);
  localparam int RESET_COUNT = (4096 > MAX_PIXELS) ? MAX_PIXELS : 4096;
  localparam logic [CNT_W-1:0] ResetCount = CNT_W'(RESET_COUNT);
  localparam logic [CNT_W-1:0] ResetSegSize = CNT_W'(RESET_COUNT / SEGMENT_COUNT);
  localparam logic [SEG_W-1:0] SegLast = SEG_W'(SEGMENT_COUNT - 1);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] seg_size_q;
  logic [IDX_W-1:0] index_q;
  logic [2:0][SUM_W-1:0] glob_sum_q;
  logic [2:0][SUM_W-1:0] seg_sum_q [SEGMENT_COUNT];
  logic [2:0][Q_W-1:0] avg_q;
  logic [2:0][Q_W-1:0] best_avg_q;
  logic [2:0][Q_W-1:0] res_q;
  logic [LUM_W-1:0] best_lum_q;
  logic [SEG_W-1:0] best_q;
  logic             out_valid_q;
  logic [3*Q_W+1:0] out_data_q;

  // Clamp the written count and derive the segment size by reciprocal multiply.
  logic [31:0]       cfg_ext;
  logic [CNT_W-1:0]  cfg_eff;
  logic [PROD_W-1:0] cfg_prod;

  always_comb begin
    cfg_ext = 32'(cfg_data_i);
    if (cfg_ext == 32'd0) cfg_eff = CNT_W'(1);
    else if (cfg_ext > 32'(MAX_PIXELS)) cfg_eff = CNT_W'(MAX_PIXELS);
    else cfg_eff = cfg_data_i;
    cfg_prod = PROD_W'(cfg_eff) * PROD_W'(Recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ResetCount;
      seg_size_q <= ResetSegSize;
    end else if (cfg_we_i) begin
      count_q <= cfg_eff;
      seg_size_q <= CNT_W'(cfg_prod >> RECIP_SHIFT);
    end
  end

  // Segment of the incoming pixel: the number of boundaries it has passed.
  logic [SEG_W-1:0] pix_seg;
  logic [BND_W-1:0] bound;
  logic             last_pixel;

  always_comb begin
    pix_seg = '0;
    bound = '0;
    for (int k = 1; k < SEGMENT_COUNT; k++) begin
      bound = BND_W'(seg_size_q) * BND_W'(k);
      if (CMP_W'(index_q) >= CMP_W'(bound)) pix_seg = pix_seg + 1'b1;
    end
  end

  assign last_pixel = (CMP_W'(index_q) + 1'b1) >= CMP_W'(count_q);

  logic [2:0][PIX_W-1:0] px;
  assign px = pixel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      glob_sum_q <= '0;
      for (int k = 0; k < SEGMENT_COUNT; k++) seg_sum_q[k] <= '0;
    end else if (cmd_i.clear) begin
      glob_sum_q <= '0;
      for (int k = 0; k < SEGMENT_COUNT; k++) seg_sum_q[k] <= '0;
    end else if (cmd_i.accum) begin
      index_q <= last_pixel ? '0 : index_q + 1'b1;
      for (int c = 0; c < 3; c++) begin
        glob_sum_q[c] <= glob_sum_q[c] + SUM_W'(px[c]);
      end
      for (int k = 0; k < SEGMENT_COUNT; k++) begin
        if (pix_seg == SEG_W'(k)) begin
          for (int c = 0; c < 3; c++) begin
            seg_sum_q[k][c] <= seg_sum_q[k][c] + SUM_W'(px[c]);
          end
        end
      end
    end
  end

  // Pixel count of the selected segment; the last one takes the remainder.
  logic [BND_W-1:0] tail_cnt;
  logic [CNT_W-1:0] seg_cnt;
  logic [SUM_W-1:0] dividend;
  logic [CNT_W-1:0] divisor;
  logic             div_done;
  logic [Q_W-1:0]   quot;

  always_comb begin
    tail_cnt = BND_W'(count_q) - BND_W'(seg_size_q) * BND_W'(SEGMENT_COUNT - 1);
    seg_cnt = (seg_i == SegLast) ? CNT_W'(tail_cnt) : seg_size_q;
    dividend = cmd_i.div_global ? glob_sum_q[cmd_i.chan] : seg_sum_q[seg_i][cmd_i.chan];
    divisor = cmd_i.div_global ? count_q : seg_cnt;
  end

  sacg_div #(
    .DIVIDEND_W(SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  logic [LUM_W-1:0]       lum;
  logic [GAMMA_IDX_W-1:0] gamma_idx;

  assign lum = LUM_W'(avg_q[0]) * LumWeightR + LUM_W'(avg_q[1]) * LumWeightG
             + LUM_W'(avg_q[2]) * LumWeightB;
  assign gamma_idx = GAMMA_IDX_W'(quot) + GAMMA_IDX_W'(best_avg_q[cmd_i.chan]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_lum_q <= '0;
      best_q <= '0;
      best_avg_q <= '0;
    end else if (cmd_i.clear) begin
      best_lum_q <= '0;
      best_q <= '0;
      best_avg_q <= '0;
    end else if (cmd_i.lum_step && (lum > best_lum_q)) begin
      best_lum_q <= lum;
      best_q <= seg_i;
      best_avg_q <= avg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_seg) avg_q[cmd_i.chan] <= quot;
    if (cmd_i.store_glob) res_q[cmd_i.chan] <= GammaLut[gamma_idx];
    if (cmd_i.load_out) out_data_q <= {2'(best_q), res_q[2], res_q[1], res_q[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign status_o.last_pixel = last_pixel;
  assign status_o.seg_empty = (seg_cnt == '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule
